[rtl/gvms_pkg.sv]
// ---------------------------------------------------------------------------
// gvms_pkg: shared types and constants for the vertex merge/split engine
// Field widths, command and status codes, controller/datapath structs.
// ---------------------------------------------------------------------------
package gvms_pkg;

    localparam int CMD_W            = 3;
    localparam int VTX_W            = 4;
    localparam int ROW_W            = 16;
    localparam int NC_W             = 5;
    localparam int STATUS_W         = 3;
    localparam int MAX_VERTICES_DEF = 16;

    typedef enum logic [CMD_W-1:0] {
        CMD_INIT     = 3'd0,
        CMD_WRITE    = 3'd1,
        CMD_READ     = 3'd2,
        CMD_IDENTIFY = 3'd3,
        CMD_CONTRACT = 3'd4,
        CMD_SPLIT    = 3'd5
    } cmd_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK     = 3'd0,
        ST_RANGE  = 3'd1,
        ST_SAME   = 3'd2,
        ST_NOEDGE = 3'd3,
        ST_FULL   = 3'd4
    } status_t;

    // controller -> datapath strobes
    typedef struct packed {
        logic capture;
        logic fetch;
        logic check;
        logic apply;
        logic sweep;
        logic finish;
        logic out_load;
    } ctrl_cmd_t;

    // datapath -> controller flags
    typedef struct packed {
        logic err;
        logic sweep_op;
        logic sweep_last;
    } dp_status_t;

endpackage

[rtl/gvms_req_if.sv]
// ---------------------------------------------------------------------------
// gvms_req_if: command channel
// Valid/ready handshake carrying one command item.
// ---------------------------------------------------------------------------
interface gvms_req_if
    import gvms_pkg::*;
();

    logic                 valid;
    logic                 ready;
    logic [CMD_W-1:0]     cmd;
    logic [VTX_W-1:0]     vertex_a;
    logic [VTX_W-1:0]     vertex_b;
    logic [ROW_W-1:0]     row_bits;
    logic [NC_W-1:0]      new_count;

    modport source (
        output valid, cmd, vertex_a, vertex_b, row_bits, new_count,
        input  ready
    );

    modport sink (
        input  valid, cmd, vertex_a, vertex_b, row_bits, new_count,
        output ready
    );

endinterface

[rtl/gvms_rsp_if.sv]
// ---------------------------------------------------------------------------
// gvms_rsp_if: result channel
// Valid/ready handshake carrying one result item.
// ---------------------------------------------------------------------------
interface gvms_rsp_if
    import gvms_pkg::*;
();

    logic                 valid;
    logic                 ready;
    logic [ROW_W-1:0]     row_out;
    logic [STATUS_W-1:0]  status;
    logic [NC_W-1:0]      count_out;

    modport source (
        output valid, row_out, status, count_out,
        input  ready
    );

    modport sink (
        input  valid, row_out, status, count_out,
        output ready
    );

endinterface

[rtl/gvms_dp.sv]
// ---------------------------------------------------------------------------
// gvms_dp: adjacency datapath
// Row memory with valid bits, operand registers, error checks, row sweep
// pipeline for merge and split, and the result register.
// ---------------------------------------------------------------------------
module gvms_dp
    import gvms_pkg::*;
#(
    parameter int MAX_VERTICES = MAX_VERTICES_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic [CMD_W-1:0]    cmd,
    input  logic [VTX_W-1:0]    vertex_a,
    input  logic [VTX_W-1:0]    vertex_b,
    input  logic [ROW_W-1:0]    row_bits,
    input  logic [NC_W-1:0]     new_count,
    input  ctrl_cmd_t           ctl,
    output dp_status_t          st,
    output logic [ROW_W-1:0]    row_out,
    output logic [STATUS_W-1:0] status,
    output logic [NC_W-1:0]     count_out
);

    localparam int NV = MAX_VERTICES;
    localparam int IW = $clog2(NV);
    localparam int CW = $clog2(NV + 1);
    localparam int WW = (CW > NC_W) ? CW : NC_W;
    localparam logic [WW-1:0] MAX_W = WW'(NV);

    // captured operands
    logic [CMD_W-1:0]    cmd_reg;
    logic [VTX_W-1:0]    a_reg;
    logic [VTX_W-1:0]    b_reg;
    logic [ROW_W-1:0]    bits_reg;
    logic [NC_W-1:0]     nc_reg;
    logic [IW-1:0]       k_reg;
    logic [IW-1:0]       r_reg;

    // matrix
    logic [NV-1:0]       mem [NV];
    logic [NV-1:0]       valid_reg;
    logic [CW-1:0]       count_reg;
    logic [NV-1:0]       rd_a_reg;
    logic [NV-1:0]       rd_b_reg;

    // sweep pipeline
    logic [CW-1:0]       issue_reg;
    logic                proc_vld_reg;
    logic [IW-1:0]       proc_idx_reg;

    // results
    logic [ROW_W-1:0]    res_row_reg;
    logic [STATUS_W-1:0] res_status_reg;
    logic [ROW_W-1:0]    row_out_reg;
    logic [STATUS_W-1:0] status_out_reg;
    logic [NC_W-1:0]     count_out_reg;

    logic [WW-1:0]       a_w;
    logic [WW-1:0]       b_w;
    logic [WW-1:0]       cnt_w;
    logic [WW-1:0]       nc_w;
    logic [IW-1:0]       a_idx;
    logic [IW-1:0]       b_idx;
    logic [IW-1:0]       n_idx;
    logic [IW-1:0]       s_idx;
    logic [CW-1:0]       s_cnt;
    logic [CW-1:0]       len;
    logic                is_merge;
    logic                is_contract;
    logic                is_split;
    logic                issue_en;
    logic                proc_write;
    status_t             err_code;
    logic [NV-1:0]       lo_mask;
    logic [NV-1:0]       proc_row;
    logic [NV-1:0]       split_row;

    function automatic logic [NV-1:0] drop_col(input logic [NV-1:0] x,
                                               input logic [IW-1:0] r);
        logic [NV-1:0] hm;
        hm = {NV{1'b1}} << r;
        return (x & ~hm) | ((x >> 1) & hm);
    endfunction

    assign a_w         = WW'(a_reg);
    assign b_w         = WW'(b_reg);
    assign cnt_w       = WW'(count_reg);
    assign nc_w        = WW'(nc_reg);
    assign a_idx       = IW'(a_reg);
    assign b_idx       = IW'(b_reg);
    assign n_idx       = count_reg[IW-1:0];
    assign is_merge    = (cmd_reg == CMD_IDENTIFY) || (cmd_reg == CMD_CONTRACT);
    assign is_contract = (cmd_reg == CMD_CONTRACT);
    assign is_split    = (cmd_reg == CMD_SPLIT);
    assign lo_mask     = ~({NV{1'b1}} << count_reg);

    // merge drops row r; split walks every live row
    assign len      = is_merge ? (count_reg - 1'b1) : count_reg;
    assign s_cnt    = (is_merge && (issue_reg >= CW'(r_reg))) ? (issue_reg + 1'b1) : issue_reg;
    assign s_idx    = s_cnt[IW-1:0];
    assign issue_en = ctl.sweep && (issue_reg < len);
    assign proc_write = ctl.sweep && proc_vld_reg;

    always_comb
    begin
        err_code = ST_OK;
        case (cmd_t'(cmd_reg))
            CMD_INIT:
            begin
                if (nc_w > MAX_W)
                    err_code = ST_RANGE;
            end
            CMD_WRITE, CMD_READ:
            begin
                if (a_w >= cnt_w)
                    err_code = ST_RANGE;
            end
            CMD_IDENTIFY, CMD_CONTRACT:
            begin
                if ((a_w >= cnt_w) || (b_w >= cnt_w))
                    err_code = ST_RANGE;
                else if (a_reg == b_reg)
                    err_code = ST_SAME;
                else if (is_contract && !rd_a_reg[b_idx])
                    err_code = ST_NOEDGE;
            end
            CMD_SPLIT:
            begin
                if (a_w >= cnt_w)
                    err_code = ST_RANGE;
                else if (cnt_w >= MAX_W)
                    err_code = ST_FULL;
            end
            default:
            begin
                err_code = ST_OK;
            end
        endcase
    end

    // per-row rewrite; rd_b_reg holds row r (merge) or the source row (split)
    always_comb
    begin
        logic [NV-1:0] x1;
        logic [NV-1:0] nb;
        logic [NV-1:0] ab;
        logic          is_k;
        nb   = NV'(1) << n_idx;
        ab   = NV'(1) << a_idx;
        is_k = (proc_idx_reg == k_reg);
        x1   = is_k ? (rd_a_reg | rd_b_reg) : rd_a_reg;
        if (x1[r_reg])
            x1[k_reg] = 1'b1;
        if (is_contract && is_k)
            x1[k_reg] = rd_a_reg[k_reg] | rd_b_reg[r_reg];
        if (is_merge)
            proc_row = drop_col(x1, r_reg);
        else if ((proc_idx_reg == a_idx) || rd_b_reg[proc_idx_reg])
            proc_row = rd_a_reg | nb;
        else
            proc_row = rd_a_reg;
        split_row = (rd_b_reg & ~ab) | ab | (rd_b_reg[a_idx] ? nb : '0);
    end

    assign st.err        = (err_code != ST_OK);
    assign st.sweep_op   = is_merge || is_split;
    assign st.sweep_last = proc_write && (CW'(proc_idx_reg) == (len - 1'b1));

    always_ff @(posedge clk)
    begin
        if (ctl.capture)
        begin
            cmd_reg  <= cmd;
            a_reg    <= vertex_a;
            b_reg    <= vertex_b;
            bits_reg <= row_bits;
            nc_reg   <= new_count;
            k_reg    <= IW'((vertex_a < vertex_b) ? vertex_a : vertex_b);
            r_reg    <= IW'((vertex_a < vertex_b) ? vertex_b : vertex_a);
        end
    end

    // memory read ports, registered
    always_ff @(posedge clk)
    begin
        if (ctl.fetch)
        begin
            rd_a_reg <= valid_reg[a_idx] ? mem[a_idx] : '0;
            if (is_merge)
                rd_b_reg <= valid_reg[r_reg] ? mem[r_reg] : '0;
            else
                rd_b_reg <= valid_reg[a_idx] ? mem[a_idx] : '0;
        end
        else if (issue_en)
        begin
            rd_a_reg <= valid_reg[s_idx] ? mem[s_idx] : '0;
        end
    end

    // memory write port
    always_ff @(posedge clk)
    begin
        if (ctl.apply && (cmd_reg == CMD_WRITE))
            mem[a_idx] <= NV'(bits_reg) & lo_mask;
        else if (proc_write)
            mem[proc_idx_reg] <= proc_row;
        else if (ctl.finish && is_split)
            mem[n_idx] <= split_row;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= '0;
            count_reg    <= '0;
            issue_reg    <= '0;
            proc_vld_reg <= 1'b0;
            proc_idx_reg <= '0;
        end
        else
        begin
            if (ctl.apply && (cmd_reg == CMD_INIT))
            begin
                valid_reg <= '0;
                count_reg <= CW'(nc_reg);
            end
            else if (ctl.apply && (cmd_reg == CMD_WRITE))
            begin
                valid_reg[a_idx] <= 1'b1;
            end
            else if (proc_write)
            begin
                valid_reg[proc_idx_reg] <= 1'b1;
            end
            else if (ctl.finish && is_merge)
            begin
                valid_reg[IW'(count_reg - 1'b1)] <= 1'b0;
                count_reg <= count_reg - 1'b1;
            end
            else if (ctl.finish && is_split)
            begin
                valid_reg[n_idx] <= 1'b1;
                count_reg <= count_reg + 1'b1;
            end

            if (ctl.check)
            begin
                issue_reg    <= '0;
                proc_vld_reg <= 1'b0;
            end
            else if (ctl.sweep)
            begin
                if (issue_en)
                    issue_reg <= issue_reg + 1'b1;
                proc_vld_reg <= issue_en;
                proc_idx_reg <= issue_reg[IW-1:0];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.check)
        begin
            res_status_reg <= err_code;
            if ((cmd_reg == CMD_READ) && (err_code == ST_OK))
                res_row_reg <= ROW_W'(rd_a_reg);
            else
                res_row_reg <= '0;
        end
        if (ctl.out_load)
        begin
            row_out_reg    <= res_row_reg;
            status_out_reg <= res_status_reg;
            count_out_reg  <= NC_W'(count_reg);
        end
    end

    assign row_out   = row_out_reg;
    assign status    = status_out_reg;
    assign count_out = count_out_reg;

    a_valid_above_count: assert property (@(posedge clk) disable iff (!rst_n)
        (valid_reg & ({NV{1'b1}} << count_reg)) == '0)
        else $error("row valid at or above vertex count");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(NV))
        else $error("vertex count above matrix size");

    a_merge_shrinks: assert property (@(posedge clk) disable iff (!rst_n)
        (ctl.finish && is_merge) |=> (count_reg == ($past(count_reg) - 1'b1)))
        else $error("merge did not remove one vertex");

    a_sweep_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        proc_write |-> (CW'(proc_idx_reg) < len))
        else $error("sweep wrote past the live rows");

endmodule

[rtl/gvms_ctrl.sv]
// ---------------------------------------------------------------------------
// gvms_ctrl: command sequencer
// Steps each item through fetch, check, merge/split sweep, result hand-off.
// ---------------------------------------------------------------------------
module gvms_ctrl
    import gvms_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       req_valid,
    output logic       req_ready,
    output logic       rsp_valid,
    input  logic       rsp_ready,
    input  dp_status_t st,
    output ctrl_cmd_t  ctl
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_FETCH,
        S_CHECK,
        S_SWEEP,
        S_FINISH,
        S_OUT
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   rsp_valid_reg;
    logic   rsp_valid_next;

    always_comb
    begin
        state_next     = state_reg;
        rsp_valid_next = rsp_valid_reg && !rsp_ready;
        ctl            = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    ctl.capture = 1'b1;
                    state_next  = S_FETCH;
                end
            end
            S_FETCH:
            begin
                ctl.fetch  = 1'b1;
                state_next = S_CHECK;
            end
            S_CHECK:
            begin
                ctl.check = 1'b1;
                if (!st.err && st.sweep_op)
                begin
                    state_next = S_SWEEP;
                end
                else
                begin
                    ctl.apply  = !st.err;
                    state_next = S_OUT;
                end
            end
            S_SWEEP:
            begin
                ctl.sweep = 1'b1;
                if (st.sweep_last)
                    state_next = S_FINISH;
            end
            S_FINISH:
            begin
                ctl.finish = 1'b1;
                state_next = S_OUT;
            end
            S_OUT:
            begin
                // hold until the output register is free
                if (!rsp_valid_reg || rsp_ready)
                begin
                    ctl.out_load   = 1'b1;
                    rsp_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    assign req_ready = (state_reg == S_IDLE);
    assign rsp_valid = rsp_valid_reg;

endmodule

[rtl/graph_vertex_merge_split.sv]
// Init, write, read, unused codes and errors pass through fetch and check to the result;
// identify/contract and split add a row sweep and a finish step before the result.
// Throughput: one item at a time; the next item is accepted in the cycle after the result is loaded.
// The sweep rewrites one row per cycle through the single row-memory write port.
// Reset: vertex count zero, all row valid bits cleared so every row reads zero; no clearing pass.
// ---------------------------------------------------------------------------
// graph_vertex_merge_split: bit adjacency matrix with vertex merge and split
// Keeps an adjacency matrix and vertex count; executes init, row write,
// row read, identify, contract and split, one result item per command item.
// ---------------------------------------------------------------------------
module graph_vertex_merge_split
    import gvms_pkg::*;
#(
    parameter int MAX_VERTICES = MAX_VERTICES_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    gvms_req_if.sink   req,
    gvms_rsp_if.source rsp
);

    // Controller and datapath talk only through these two structs.
    // The controller sequences each item:
    //   fetch  - read row a (and row r or the split source) into the read registers
    //   check  - decide status; simple commands apply here
    //   sweep  - stream rows through the rewrite stage, one per cycle
    //   finish - drop the last row (merge) or append the new row (split)
    //   out    - move the result into the output register once it is free
    ctrl_cmd_t  ctl;
    dp_status_t st;

    gvms_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req.valid),
        .req_ready (req.ready),
        .rsp_valid (rsp.valid),
        .rsp_ready (rsp.ready),
        .st        (st),
        .ctl       (ctl)
    );

    // Matrix storage, checks and the row rewrite pipeline.
    gvms_dp #(
        .MAX_VERTICES (MAX_VERTICES)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (req.cmd),
        .vertex_a  (req.vertex_a),
        .vertex_b  (req.vertex_b),
        .row_bits  (req.row_bits),
        .new_count (req.new_count),
        .ctl       (ctl),
        .st        (st),
        .row_out   (rsp.row_out),
        .status    (rsp.status),
        .count_out (rsp.count_out)
    );

endmodule

[bench/graph_vertex_merge_split_test.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// graph_vertex_merge_split_test: self-checking bench for the vertex engine
// Drives command items through the request channel, predicts every result
// item from a private copy of the matrix and vertex count, and compares the
// response channel field by field. A short directed table covers the
// corner cases, then random well-formed sequences run with random idling.
// ---------------------------------------------------------------------------
module graph_vertex_merge_split_test;
    import gvms_pkg::*;

    localparam int MAX_V         = MAX_VERTICES_DEF;
    localparam int RANDOM_ITEMS  = 1650;
    localparam int CALM_ITEMS    = 150;     // tail of the run with no idling
    localparam int DRAIN_EVERY   = 550;     // sender waits for an empty pipe this often
    localparam int TAIL_CYCLES   = 2 * (MAX_V + 5);
    localparam int CYCLE_LIMIT   = 600000;

    // codes outside the package enum: the block must ignore them
    localparam logic [CMD_W-1:0] CMD_SPARE6 = 3'd6;
    localparam logic [CMD_W-1:0] CMD_SPARE7 = 3'd7;

    typedef struct packed {
        logic [CMD_W-1:0] cmd;
        logic [VTX_W-1:0] vertex_a;
        logic [VTX_W-1:0] vertex_b;
        logic [ROW_W-1:0] row_bits;
        logic [NC_W-1:0]  new_count;
    } graph_cmd_t;

    typedef struct packed {
        logic [ROW_W-1:0] row_out;
        status_t          status;
        logic [NC_W-1:0]  count_out;
    } graph_rsp_t;

    typedef struct {
        graph_cmd_t c;
        bit         typed;      // expectation written in the table
        graph_rsp_t r;
    } directed_row_t;

    logic clk = 1'b0;
    logic rst_n;

    gvms_req_if cmd_ch ();
    gvms_rsp_if res_ch ();

    graph_vertex_merge_split #(
        .MAX_VERTICES (MAX_V)
    ) uut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (cmd_ch),
        .rsp   (res_ch)
    );

    always #5 clk = ~clk;

    // Shadow copy of the block's state.
    logic [ROW_W-1:0] matrix_model [MAX_V];
    int unsigned      count_model;

    graph_rsp_t    pending_results [$];
    directed_row_t directed_rows [$];
    graph_rsp_t    oldest_result;

    int  error_count = 0;
    int  cycle_count = 0;
    bit  calm = 1'b0;
    int  cmd_tally [8];
    int  status_tally [5];

    // -----------------------------------------------------------------------
    // Predictor
    // -----------------------------------------------------------------------

    // Remove column r from a row; higher columns move down by one.
    function automatic logic [ROW_W-1:0] drop_column(logic [ROW_W-1:0] x, int unsigned r);
        logic [31:0] wide;
        logic [31:0] lowp;
        logic [31:0] highp;
        wide  = {16'h0000, x};
        lowp  = wide & ((32'h1 << r) - 32'h1);
        highp = (wide >> (r + 1)) << r;
        return lowp[ROW_W-1:0] | highp[ROW_W-1:0];
    endfunction

    // Apply one command to the shadow state and return the result it causes.
    task automatic predict_command(input graph_cmd_t c, output graph_rsp_t r);
        int unsigned n;
        int unsigned a;
        int unsigned b;
        int unsigned k;
        int unsigned hi;
        int unsigned nc;
        int unsigned i;
        logic [31:0] mask;
        logic [ROW_W-1:0] src;
        logic [ROW_W-1:0] fresh;
        logic loops;
        n  = count_model;
        a  = int'(c.vertex_a);
        b  = int'(c.vertex_b);
        nc = int'(c.new_count);
        r.row_out = '0;
        r.status  = ST_OK;
        case (c.cmd)
            CMD_INIT:
            begin
                if (nc > MAX_V)
                    r.status = ST_RANGE;
                else
                begin
                    for (i = 0; i < MAX_V; i++)
                        matrix_model[i] = '0;
                    count_model = nc;
                end
            end
            CMD_WRITE:
            begin
                if (a >= n)
                    r.status = ST_RANGE;
                else
                begin
                    // keep only the columns that exist
                    mask = (32'h1 << n) - 32'h1;
                    matrix_model[a] = c.row_bits & mask[ROW_W-1:0];
                end
            end
            CMD_READ:
            begin
                if (a >= n)
                    r.status = ST_RANGE;
                else
                    r.row_out = matrix_model[a];
            end
            CMD_IDENTIFY, CMD_CONTRACT:
            begin
                if (a >= n || b >= n)
                    r.status = ST_RANGE;
                else if (a == b)
                    r.status = ST_SAME;
                else if (c.cmd == CMD_CONTRACT && !matrix_model[a][b])
                    r.status = ST_NOEDGE;
                else
                begin
                    k  = (a < b) ? a : b;
                    hi = (a < b) ? b : a;
                    loops = matrix_model[k][k] | matrix_model[hi][hi];
                    matrix_model[k] = matrix_model[k] | matrix_model[hi];
                    for (i = 0; i < n; i++)
                        if (matrix_model[i][hi])
                            matrix_model[i][k] = 1'b1;
                    // contract keeps only the original loops on the kept vertex
                    if (c.cmd == CMD_CONTRACT)
                        matrix_model[k][k] = loops;
                    for (i = hi; i + 1 < n; i++)
                        matrix_model[i] = matrix_model[i + 1];
                    matrix_model[n - 1] = '0;
                    for (i = 0; i + 1 < n; i++)
                        matrix_model[i] = drop_column(matrix_model[i], hi);
                    count_model = n - 1;
                end
            end
            CMD_SPLIT:
            begin
                if (a >= n)
                    r.status = ST_RANGE;
                else if (n >= MAX_V)
                    r.status = ST_FULL;
                else
                begin
                    src = matrix_model[a];
                    fresh = src;
                    fresh[a] = 1'b1;
                    if (src[a])
                        fresh[n] = 1'b1;
                    for (i = 0; i < n; i++)
                        if (i != a && src[i])
                            matrix_model[i][n] = 1'b1;
                    matrix_model[a][n] = 1'b1;
                    matrix_model[n] = fresh;
                    count_model = n + 1;
                end
            end
            default:
            begin
                // unused codes leave everything alone
            end
        endcase
        r.count_out = count_model[NC_W-1:0];
    endtask

    // -----------------------------------------------------------------------
    // Stimulus helpers
    // -----------------------------------------------------------------------

    task automatic add_directed(input logic [CMD_W-1:0] cmd, input int a, input int b,
                                input logic [ROW_W-1:0] bits, input int nc, input bit typed,
                                input logic [ROW_W-1:0] row, input status_t st,
                                input int count);
        directed_row_t d;
        d.c.cmd       = cmd;
        d.c.vertex_a  = a[VTX_W-1:0];
        d.c.vertex_b  = b[VTX_W-1:0];
        d.c.row_bits  = bits;
        d.c.new_count = nc[NC_W-1:0];
        d.typed       = typed;
        d.r.row_out   = row;
        d.r.status    = st;
        d.r.count_out = count[NC_W-1:0];
        directed_rows.push_back(d);
    endtask

    // Pick a vertex that exists, or any index when the graph is empty.
    function automatic logic [VTX_W-1:0] pick_vertex();
        int unsigned v;
        if (count_model > 0)
            v = $urandom_range(0, count_model - 1);
        else
            v = $urandom_range(0, 15);
        return v[VTX_W-1:0];
    endfunction

    // Build one random command, mostly well formed against the shadow state.
    task automatic make_random_command(output graph_cmd_t c);
        int unsigned roll;
        int unsigned nc;
        int unsigned j;
        int unsigned nbrs [$];
        logic [31:0] r32;
        logic [31:0] code;
        r32 = $urandom;
        c.vertex_a  = r32[3:0];
        c.vertex_b  = r32[7:4];
        c.new_count = r32[12:8];
        r32 = $urandom;
        c.row_bits  = r32[ROW_W-1:0];
        c.cmd       = CMD_READ;
        roll = $urandom_range(0, 99);
        if ((count_model < 2 && roll < 70) || roll < 5)
        begin
            c.cmd = CMD_INIT;
            if ($urandom_range(0, 9) == 0)
                nc = $urandom_range(0, 31);
            else if ($urandom_range(0, 4) == 0)
                nc = MAX_V;
            else
                nc = $urandom_range(2, MAX_V);
            c.new_count = nc[NC_W-1:0];
        end
        else if (roll < 30)
        begin
            c.cmd = CMD_WRITE;
            c.vertex_a = pick_vertex();
            // mix dense and sparse rows
            if ($urandom_range(0, 1) == 0)
            begin
                r32 = $urandom & $urandom & $urandom;
                c.row_bits = r32[ROW_W-1:0];
            end
        end
        else if (roll < 48)
        begin
            c.cmd = CMD_READ;
            c.vertex_a = pick_vertex();
        end
        else if (roll < 60)
        begin
            c.cmd = CMD_IDENTIFY;
            c.vertex_a = pick_vertex();
            c.vertex_b = pick_vertex();
        end
        else if (roll < 75)
        begin
            c.cmd = CMD_CONTRACT;
            c.vertex_a = pick_vertex();
            for (j = 0; j < count_model; j++)
                if (j != c.vertex_a && matrix_model[c.vertex_a][j])
                    nbrs.push_back(j);
            if (nbrs.size() > 0 && $urandom_range(0, 4) != 0)
            begin
                j = nbrs[$urandom_range(0, nbrs.size() - 1)];
                c.vertex_b = j[VTX_W-1:0];
            end
            else
                c.vertex_b = pick_vertex();
        end
        else if (roll < 90)
        begin
            c.cmd = CMD_SPLIT;
            c.vertex_a = pick_vertex();
        end
        else if (roll < 93)
            c.cmd = $urandom_range(0, 1) ? CMD_SPARE6 : CMD_SPARE7;
        else
        begin
            // noise: any code, operands over the whole field range
            code = $urandom_range(0, 7);
            c.cmd = code[CMD_W-1:0];
        end
    endtask

    // Present one item, hold it until accepted, then record its expectation.
    task automatic issue_command(input graph_cmd_t c, input bit typed,
                                 input graph_rsp_t typed_rsp);
        graph_rsp_t predicted;
        int unsigned gap;
        if (!calm && $urandom_range(0, 4) == 0)
        begin
            gap = $urandom_range(1, 13);
            cmd_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        cmd_ch.valid     <= 1'b1;
        cmd_ch.cmd       <= c.cmd;
        cmd_ch.vertex_a  <= c.vertex_a;
        cmd_ch.vertex_b  <= c.vertex_b;
        cmd_ch.row_bits  <= c.row_bits;
        cmd_ch.new_count <= c.new_count;
        @(posedge clk);
        while (cmd_ch.ready !== 1'b1)
            @(posedge clk);
        predict_command(c, predicted);
        cmd_tally[c.cmd]++;
        status_tally[predicted.status]++;
        pending_results.push_back(typed ? typed_rsp : predicted);
    endtask

    // Hold the request side idle until every outstanding result has come back.
    task automatic wait_for_empty_pipe();
        cmd_ch.valid <= 1'b0;
        do
            @(posedge clk);
        while (pending_results.size() != 0);
    endtask

    // -----------------------------------------------------------------------
    // Reset and initial drive
    // -----------------------------------------------------------------------
    initial
    begin
        rst_n            <= 1'b0;
        cmd_ch.valid     <= 1'b0;
        cmd_ch.cmd       <= CMD_INIT;
        cmd_ch.vertex_a  <= '0;
        cmd_ch.vertex_b  <= '0;
        cmd_ch.row_bits  <= '0;
        cmd_ch.new_count <= '0;
        res_ch.ready     <= 1'b0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
    end

    // -----------------------------------------------------------------------
    // Result side: random stall bursts, none once the run goes calm
    // -----------------------------------------------------------------------
    initial
    begin
        @(posedge rst_n);
        @(posedge clk);
        res_ch.ready <= 1'b1;
        forever
        begin
            @(posedge clk);
            if (!calm && $urandom_range(0, 5) == 0)
            begin
                res_ch.ready <= 1'b0;
                repeat ($urandom_range(1, 13)) @(posedge clk);
                res_ch.ready <= 1'b1;
            end
        end
    end

    // -----------------------------------------------------------------------
    // Result check: every accepted result against the oldest expectation
    // -----------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (rst_n === 1'b1 && res_ch.valid === 1'b1 && res_ch.ready === 1'b1)
        begin
            if (pending_results.size() == 0)
            begin
                $error("unexpected result item: row_out %h status %0d count_out %0d",
                       res_ch.row_out, res_ch.status, res_ch.count_out);
                error_count++;
            end
            else
            begin
                oldest_result = pending_results.pop_front();
                if (res_ch.row_out !== oldest_result.row_out)
                begin
                    $error("row_out: expected %h, got %h",
                           oldest_result.row_out, res_ch.row_out);
                    error_count++;
                end
                if (res_ch.status !== oldest_result.status)
                begin
                    $error("status: expected %0d, got %0d",
                           oldest_result.status, res_ch.status);
                    error_count++;
                end
                if (res_ch.count_out !== oldest_result.count_out)
                begin
                    $error("count_out: expected %0d, got %0d",
                           oldest_result.count_out, res_ch.count_out);
                    error_count++;
                end
            end
        end
    end

    // Watchdog: a hung handshake ends the run as a failure.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_count, pending_results.size());
            $display("FAILURE");
            $finish;
        end
    end

    // -----------------------------------------------------------------------
    // Main sequence
    // -----------------------------------------------------------------------
    initial
    begin
        graph_cmd_t    item;
        graph_rsp_t    unused_rsp;
        directed_row_t d;
        int            idx;

        unused_rsp = '0;

        // Directed table. Rows with typed=1 carry the expectation in place;
        // the rest are checked against the predictor.
        //           cmd           a   b   row_bits  nc  typed row      status     count
        add_directed(CMD_READ,     0,  0,  16'h0000, 0,  1, 16'h0000, ST_RANGE,  0);  // empty after reset
        add_directed(CMD_SPLIT,    0,  0,  16'h0000, 0,  1, 16'h0000, ST_RANGE,  0);
        add_directed(CMD_INIT,     0,  0,  16'h0000, 31, 1, 16'h0000, ST_RANGE,  0);  // count too big
        add_directed(CMD_INIT,     0,  0,  16'h0000, 17, 1, 16'h0000, ST_RANGE,  0);
        add_directed(CMD_INIT,     0,  0,  16'h0000, 16, 1, 16'h0000, ST_OK,     16);
        add_directed(CMD_WRITE,    15, 0,  16'hFFFF, 0,  1, 16'h0000, ST_OK,     16);
        add_directed(CMD_READ,     15, 0,  16'h0000, 0,  1, 16'hFFFF, ST_OK,     16);
        add_directed(CMD_SPLIT,    3,  0,  16'h0000, 0,  1, 16'h0000, ST_FULL,   16); // matrix full
        add_directed(CMD_IDENTIFY, 5,  5,  16'h0000, 0,  1, 16'h0000, ST_SAME,   16);
        add_directed(CMD_CONTRACT, 2,  2,  16'h0000, 0,  1, 16'h0000, ST_SAME,   16);
        add_directed(CMD_CONTRACT, 0,  1,  16'h0000, 0,  1, 16'h0000, ST_NOEDGE, 16);
        add_directed(CMD_CONTRACT, 15, 0,  16'h0000, 0,  0, 16'h0000, ST_OK,     0);  // top row merges
        add_directed(CMD_READ,     0,  0,  16'h0000, 0,  0, 16'h0000, ST_OK,     0);
        add_directed(CMD_IDENTIFY, 14, 3,  16'h0000, 0,  0, 16'h0000, ST_OK,     0);
        add_directed(CMD_SPARE6,   0,  0,  16'hFFFF, 0,  0, 16'h0000, ST_OK,     0);
        add_directed(CMD_SPARE7,   15, 15, 16'hFFFF, 31, 0, 16'h0000, ST_OK,     0);
        add_directed(CMD_INIT,     0,  0,  16'h0000, 4,  1, 16'h0000, ST_OK,     4);
        add_directed(CMD_WRITE,    1,  0,  16'hFFFE, 0,  1, 16'h0000, ST_OK,     4);  // wide row clipped
        add_directed(CMD_READ,     1,  0,  16'h0000, 0,  1, 16'h000E, ST_OK,     4);
        add_directed(CMD_WRITE,    0,  0,  16'h0003, 0,  0, 16'h0000, ST_OK,     0);
        add_directed(CMD_CONTRACT, 1,  0,  16'h0000, 0,  1, 16'h0000, ST_NOEDGE, 4);
        add_directed(CMD_CONTRACT, 0,  1,  16'h0000, 0,  0, 16'h0000, ST_OK,     0);
        add_directed(CMD_SPLIT,    0,  0,  16'h0000, 0,  0, 16'h0000, ST_OK,     0);
        add_directed(CMD_READ,     3,  0,  16'h0000, 0,  0, 16'h0000, ST_OK,     0);
        add_directed(CMD_IDENTIFY, 0,  15, 16'h0000, 0,  1, 16'h0000, ST_RANGE,  4);
        add_directed(CMD_INIT,     0,  0,  16'h0000, 0,  1, 16'h0000, ST_OK,     0);

        @(posedge rst_n);
        @(posedge clk);

        foreach (directed_rows[i])
        begin
            d = directed_rows[i];
            issue_command(d.c, d.typed, d.r);
        end

        for (idx = 0; idx < RANDOM_ITEMS; idx++)
        begin
            if (idx == RANDOM_ITEMS - CALM_ITEMS)
                calm = 1'b1;
            // drain the pipe now and then so the block also starts from idle
            if (idx > 0 && idx % DRAIN_EVERY == 0)
                wait_for_empty_pipe();
            make_random_command(item);
            issue_command(item, 1'b0, unused_rsp);
        end
        cmd_ch.valid <= 1'b0;

        // Wait out the stragglers, then watch for anything extra.
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("%0d items: init %0d, write %0d, read %0d, identify %0d, contract %0d, split %0d, unused %0d",
                 directed_rows.size() + RANDOM_ITEMS, cmd_tally[CMD_INIT], cmd_tally[CMD_WRITE],
                 cmd_tally[CMD_READ], cmd_tally[CMD_IDENTIFY], cmd_tally[CMD_CONTRACT],
                 cmd_tally[CMD_SPLIT], cmd_tally[CMD_SPARE6] + cmd_tally[CMD_SPARE7]);
        $display("status mix: ok %0d, range %0d, same %0d, no edge %0d, full %0d; %0d mismatches",
                 status_tally[ST_OK], status_tally[ST_RANGE], status_tally[ST_SAME],
                 status_tally[ST_NOEDGE], status_tally[ST_FULL], error_count);
        if (error_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
